>>> rtl/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types, byte codes and helpers for the map-subset packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mpp_pkg;

   // map nesting stack
   localparam int MAX_DEPTH   = 8;
   localparam int SP_W        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int COUNT_W     = 16;

   // running byte offset
   localparam int OFFSET_BITS = 16;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // header bytes and prefixes
   localparam logic [7:0] HDR_MAP16   = 8'hDE;
   localparam logic [7:0] HDR_STR8    = 8'hD9;
   localparam logic [7:0] HDR_FLOAT32 = 8'hCA;
   localparam logic [7:0] HDR_ARRAY16 = 8'hDC;
   localparam logic [3:0] PFX_FIXMAP  = 4'h8;
   localparam logic [3:0] PFX_FIXARR  = 4'h9;
   localparam logic [2:0] PFX_FIXSTR  = 3'b101;
   localparam logic [7:0] FLOAT_BYTES = 8'd4;

   typedef enum logic [2:0] {
      KIND_STRUCT  = 3'd0,
      KIND_KEY     = 3'd1,
      KIND_UINT    = 3'd2,
      KIND_STRING  = 3'd3,
      KIND_FLOAT   = 3'd4,
      KIND_IGNORED = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STK_NONE  = 2'd0,
      STK_PUSH  = 2'd1,
      STK_OPEN  = 2'd2,
      STK_CLOSE = 2'd3
   } stk_op_type;

   typedef struct packed {
      stk_op_type         op;
      logic [SP_W-1:0]    level;
      logic [COUNT_W-1:0] count;
   } stk_cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        in_array;
      logic [15:0] index;
      logic [2:0]  depth;
      logic        tlast;
      logic        perr;
      logic [15:0] eoff;
      logic        done;
   } tok_type;

   function automatic logic [2:0] depth_code(input logic [SP_W-1:0] sp);
      logic [SP_W+2:0] w;
      w = (SP_W+3)'(sp);
      return w[2:0];
   endfunction

   function automatic logic [15:0] offset_code(input logic [OFFSET_BITS-1:0] off);
      logic [OFFSET_BITS+15:0] w;
      w = (OFFSET_BITS+16)'(off);
      return w[15:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/mpp_stack.sv
// ----------------------------------------------------------------------------
// mpp_stack
// Pair-count stack of open maps; resolves map close-out with a combinational search.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_stack (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        fire,
   input  wire logic                        clear,
   input  wire mpp_pkg::stk_cmd_type        cmd,
   output logic [mpp_pkg::SP_W-1:0]         sp,
   output logic                             to_key
);

   logic [mpp_pkg::COUNT_W-1:0] stack_ff [mpp_pkg::MAX_DEPTH];
   logic [mpp_pkg::SP_W-1:0]    sp_ff;
   logic [mpp_pkg::SP_W-1:0]    sp_in;

   logic                        chain;
   logic [mpp_pkg::SP_W-1:0]    chain_from;
   logic                        found;
   logic [mpp_pkg::SP_W-1:0]    hit;
   logic                        wr_en;
   logic [mpp_pkg::SP_W-1:0]    wr_addr;
   logic [mpp_pkg::COUNT_W-1:0] wr_data;

   assign sp = sp_ff;

   // where a close-out chain starts
   always_comb begin
      chain      = 1'b0;
      chain_from = sp_ff;
      case (cmd.op)
         mpp_pkg::STK_OPEN: begin
            if (cmd.count == '0 && cmd.level != '0) begin
               chain      = 1'b1;
               chain_from = cmd.level - 1'b1;
            end
         end
         mpp_pkg::STK_CLOSE: begin
            chain = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // innermost level at or below the start that still has pairs left after this one
   always_comb begin
      found = 1'b0;
      hit   = '0;
      for (int k = 0; k < mpp_pkg::MAX_DEPTH; k++) begin
         if (k <= int'(chain_from) && (|stack_ff[k][mpp_pkg::COUNT_W-1:1])) begin
            found = 1'b1;
            hit   = mpp_pkg::SP_W'(k);
         end
      end
   end

   always_comb begin
      sp_in   = sp_ff;
      to_key  = 1'b0;
      wr_en   = 1'b0;
      wr_addr = cmd.level;
      wr_data = cmd.count;
      case (cmd.op)
         mpp_pkg::STK_PUSH: begin
            sp_in = sp_ff + 1'b1;
         end
         mpp_pkg::STK_OPEN: begin
            if (cmd.count != '0) begin
               wr_en  = 1'b1;
               sp_in  = cmd.level;
               to_key = 1'b1;
            end else begin
               sp_in = '0;
            end
         end
         default: begin
         end
      endcase
      if (chain) begin
         if (found) begin
            wr_en   = 1'b1;
            wr_addr = hit;
            wr_data = stack_ff[hit] - 1'b1;
            sp_in   = hit;
            to_key  = 1'b1;
         end else begin
            sp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         for (int k = 0; k < mpp_pkg::MAX_DEPTH; k++) begin
            stack_ff[k] <= '0;
         end
      end else if (fire) begin
         if (clear) begin
            sp_ff <= '0;
         end else begin
            sp_ff <= sp_in;
            if (wr_en) begin
               stack_ff[wr_addr] <= wr_data;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/mpp_engine.sv
// ----------------------------------------------------------------------------
// mpp_engine
// Per-byte parse state machine: phase, lengths, array position and errors.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            byte_in,
   input  wire logic                  last_byte,
   input  wire logic [mpp_pkg::SP_W-1:0] sp,
   input  wire logic                  to_key,
   output mpp_pkg::stk_cmd_type       cmd,
   output mpp_pkg::tok_type           tok
);

   typedef enum logic [12:0] {
      PH_TOP         = 13'b0000000000001,
      PH_MAPLEN_HI   = 13'b0000000000010,
      PH_MAPLEN_LO   = 13'b0000000000100,
      PH_KEY_HDR     = 13'b0000000001000,
      PH_KEYLEN      = 13'b0000000010000,
      PH_KEY_BYTES   = 13'b0000000100000,
      PH_VALUE       = 13'b0000001000000,
      PH_STR_BYTES   = 13'b0000010000000,
      PH_FLOAT_BYTES = 13'b0000100000000,
      PH_ARRLEN_HI   = 13'b0001000000000,
      PH_ARRLEN_LO   = 13'b0010000000000,
      PH_ARR_ELEM    = 13'b0100000000000,
      PH_DONE        = 13'b1000000000000
   } phase_type;

   phase_type                         phase_ff, phase_pre, phase_in;
   logic [15:0]                       array_left_ff, array_left_in;
   logic [15:0]                       array_index_ff, array_index_in;
   logic [7:0]                        bytes_left_ff, bytes_left_in;
   logic [7:0]                        len_hi_ff, len_hi_in;
   logic                              err_ff, err_pre, err_in;
   logic [mpp_pkg::OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic [mpp_pkg::OFFSET_BITS-1:0]   first_ff, first_pre, first_in;

   mpp_pkg::kind_type                 kind;
   logic                              in_array;
   logic [15:0]                       index;
   logic [2:0]                        depth;
   logic                              tlast;
   logic                              bad;
   logic                              val_cmp;
   logic                              elem_cmp;
   logic                              use_stk;

   always_comb begin
      phase_pre      = phase_ff;
      array_left_in  = array_left_ff;
      array_index_in = array_index_ff;
      bytes_left_in  = bytes_left_ff;
      len_hi_in      = len_hi_ff;
      err_pre        = err_ff;
      first_pre      = first_ff;
      kind           = mpp_pkg::KIND_STRUCT;
      in_array       = 1'b0;
      index          = '0;
      depth          = mpp_pkg::depth_code(sp);
      tlast          = 1'b0;
      bad            = 1'b0;
      val_cmp        = 1'b0;
      elem_cmp       = 1'b0;
      cmd.op         = mpp_pkg::STK_NONE;
      cmd.level      = sp;
      cmd.count      = '0;

      if (err_ff || phase_ff == PH_DONE) begin
         kind  = mpp_pkg::KIND_IGNORED;
         depth = '0;
      end else begin
         case (phase_ff)
            PH_TOP: begin
               if (byte_in[7:4] == mpp_pkg::PFX_FIXMAP) begin
                  cmd.op    = mpp_pkg::STK_OPEN;
                  cmd.level = '0;
                  cmd.count = 16'(byte_in[3:0]);
               end else if (byte_in == mpp_pkg::HDR_MAP16) begin
                  phase_pre = PH_MAPLEN_HI;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MAPLEN_HI: begin
               len_hi_in = byte_in;
               phase_pre = PH_MAPLEN_LO;
            end
            PH_MAPLEN_LO: begin
               cmd.op    = mpp_pkg::STK_OPEN;
               cmd.count = {len_hi_ff, byte_in};
            end
            PH_KEY_HDR: begin
               if (byte_in[7:5] == mpp_pkg::PFX_FIXSTR) begin
                  bytes_left_in = 8'(byte_in[4:0]);
                  phase_pre     = (byte_in[4:0] != '0) ? PH_KEY_BYTES : PH_VALUE;
               end else if (byte_in == mpp_pkg::HDR_STR8) begin
                  phase_pre = PH_KEYLEN;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_KEYLEN: begin
               bytes_left_in = byte_in;
               phase_pre     = (byte_in != '0) ? PH_KEY_BYTES : PH_VALUE;
            end
            PH_KEY_BYTES: begin
               kind = mpp_pkg::KIND_KEY;
               if (bytes_left_ff <= 8'd1) begin
                  tlast         = 1'b1;
                  bytes_left_in = '0;
                  phase_pre     = PH_VALUE;
               end else begin
                  bytes_left_in = bytes_left_ff - 8'd1;
               end
            end
            PH_VALUE: begin
               if (!byte_in[7]) begin
                  kind    = mpp_pkg::KIND_UINT;
                  val_cmp = 1'b1;
               end else if (byte_in[7:5] == mpp_pkg::PFX_FIXSTR) begin
                  bytes_left_in = 8'(byte_in[4:0]);
                  if (byte_in[4:0] != '0) begin
                     phase_pre = PH_STR_BYTES;
                  end else begin
                     val_cmp = 1'b1;
                  end
               end else if (byte_in == mpp_pkg::HDR_FLOAT32) begin
                  bytes_left_in = mpp_pkg::FLOAT_BYTES;
                  phase_pre     = PH_FLOAT_BYTES;
               end else if (byte_in[7:4] == mpp_pkg::PFX_FIXARR) begin
                  array_index_in = '0;
                  array_left_in  = 16'(byte_in[3:0]);
                  if (byte_in[3:0] != '0) begin
                     phase_pre = PH_ARR_ELEM;
                  end else begin
                     val_cmp = 1'b1;
                  end
               end else if (byte_in == mpp_pkg::HDR_ARRAY16) begin
                  phase_pre = PH_ARRLEN_HI;
               end else if (byte_in[7:4] == mpp_pkg::PFX_FIXMAP ||
                            byte_in == mpp_pkg::HDR_MAP16) begin
                  if (sp == mpp_pkg::SP_W'(mpp_pkg::MAX_DEPTH - 1)) begin
                     bad = 1'b1;   // nesting too deep
                  end else if (byte_in == mpp_pkg::HDR_MAP16) begin
                     cmd.op    = mpp_pkg::STK_PUSH;
                     phase_pre = PH_MAPLEN_HI;
                  end else begin
                     cmd.op    = mpp_pkg::STK_OPEN;
                     cmd.level = sp + 1'b1;
                     cmd.count = 16'(byte_in[3:0]);
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            PH_STR_BYTES, PH_FLOAT_BYTES: begin
               kind = (phase_ff == PH_STR_BYTES) ? mpp_pkg::KIND_STRING : mpp_pkg::KIND_FLOAT;
               if (array_left_ff != '0) begin
                  in_array = 1'b1;
                  index    = array_index_ff;
               end
               if (bytes_left_ff <= 8'd1) begin
                  tlast         = 1'b1;
                  bytes_left_in = '0;
                  if (array_left_ff != '0) begin
                     elem_cmp = 1'b1;
                  end else begin
                     val_cmp = 1'b1;
                  end
               end else begin
                  bytes_left_in = bytes_left_ff - 8'd1;
               end
            end
            PH_ARRLEN_HI: begin
               len_hi_in = byte_in;
               phase_pre = PH_ARRLEN_LO;
            end
            PH_ARRLEN_LO: begin
               array_index_in = '0;
               array_left_in  = {len_hi_ff, byte_in};
               if ({len_hi_ff, byte_in} != '0) begin
                  phase_pre = PH_ARR_ELEM;
               end else begin
                  val_cmp = 1'b1;
               end
            end
            PH_ARR_ELEM: begin
               in_array = 1'b1;
               index    = array_index_ff;
               if (!byte_in[7]) begin
                  kind     = mpp_pkg::KIND_UINT;
                  elem_cmp = 1'b1;
               end else if (byte_in[7:5] == mpp_pkg::PFX_FIXSTR) begin
                  bytes_left_in = 8'(byte_in[4:0]);
                  if (byte_in[4:0] != '0) begin
                     phase_pre = PH_STR_BYTES;
                  end else begin
                     elem_cmp = 1'b1;
                  end
               end else if (byte_in == mpp_pkg::HDR_FLOAT32) begin
                  bytes_left_in = mpp_pkg::FLOAT_BYTES;
                  phase_pre     = PH_FLOAT_BYTES;
               end else begin
                  bad = 1'b1;
               end
            end
            default: begin
               bad = 1'b1;
            end
         endcase

         // array element finished; the last one also finishes the value
         if (elem_cmp) begin
            array_left_in = array_left_ff - 16'd1;
            if (array_left_in == '0) begin
               array_index_in = '0;
               val_cmp        = 1'b1;
            end else begin
               array_index_in = array_index_ff + 16'd1;
               phase_pre      = PH_ARR_ELEM;
            end
         end
         if (val_cmp) begin
            cmd.op = mpp_pkg::STK_CLOSE;
         end

         if (bad) begin
            err_pre   = 1'b1;
            first_pre = offset_ff;
            kind      = mpp_pkg::KIND_IGNORED;
            in_array  = 1'b0;
            index     = '0;
            depth     = '0;
            tlast     = 1'b0;
         end
      end
   end

   // stack resolves the phase after a map opens or a value completes
   always_comb begin
      use_stk  = (cmd.op == mpp_pkg::STK_OPEN) || (cmd.op == mpp_pkg::STK_CLOSE);
      phase_in = use_stk ? (to_key ? PH_KEY_HDR : PH_DONE) : phase_pre;
      err_in   = err_pre;
      first_in = first_pre;
      // packet ends before the top map is complete
      if (last_byte && !err_pre && phase_in != PH_DONE) begin
         err_in   = 1'b1;
         first_in = offset_ff;
      end
      offset_in = (offset_ff != mpp_pkg::OFFSET_MAX) ? offset_ff + 1'b1 : offset_ff;

      tok.kind     = kind;
      tok.data     = byte_in;
      tok.in_array = in_array;
      tok.index    = index;
      tok.depth    = depth;
      tok.tlast    = tlast;
      tok.perr     = err_in;
      tok.eoff     = err_in ? mpp_pkg::offset_code(first_in) : '0;
      tok.done     = last_byte || (phase_ff != PH_DONE && phase_in == PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last_byte)) begin
         phase_ff       <= PH_TOP;
         array_left_ff  <= '0;
         array_index_ff <= '0;
         bytes_left_ff  <= '0;
         len_hi_ff      <= '0;
         err_ff         <= 1'b0;
         offset_ff      <= '0;
         first_ff       <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         array_left_ff  <= array_left_in;
         array_index_ff <= array_index_in;
         bytes_left_ff  <= bytes_left_in;
         len_hi_ff      <= len_hi_in;
         err_ff         <= err_in;
         offset_ff      <= offset_in;
         first_ff       <= first_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/msgpack_map_subset_parser.sv
// ----------------------------------------------------------------------------
// msgpack_map_subset_parser
// Byte-wise parser for a map-rooted subset of the binary object format.
//
//   channel  dir  ports                       content
//   req_     in   tvalid/tready/tdata/tlast   one packet byte, tlast = packet end
//   rsp_     out  tvalid/tready/tdata/tuser/  one token per byte, tuser = kind,
//                 tlast                       tlast = packet done
//
// One byte per cycle sustained while rsp_tready keeps the result register free; an
// accepted byte passes the input register, then the result register. The per-byte
// phase update and the combinational map close-out search over the pair-count stack set the cycle.
// Reset is synchronous and clears all control state; each packet end also
// returns the parser to its idle state. A stalled result holds the input
// register, which in turn drops req_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_map_subset_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] data_byte, [8] in_array,
                                         // [24:9] element_index, [27:25] nest_depth,
                                         // [28] token_last, [29] parse_error,
                                         // [45:30] error_offset, [47:46] zero
   output logic [2:0]       rsp_tuser,   // [2:0] token_kind
   output logic             rsp_tlast    // packet_done
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;
   logic                      out_valid_ff;
   mpp_pkg::tok_type          out_tok_ff;

   logic                      out_free;
   logic                      fire;
   logic                      req_take;
   mpp_pkg::stk_cmd_type      cmd;
   mpp_pkg::tok_type          tok;
   logic [mpp_pkg::SP_W-1:0]  sp;
   logic                      to_key;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   mpp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .byte_in   (in_byte_ff),
      .last_byte (in_last_ff),
      .sp        (sp),
      .to_key    (to_key),
      .cmd       (cmd),
      .tok       (tok)
   );

   mpp_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .clear  (in_last_ff),
      .cmd    (cmd),
      .sp     (sp),
      .to_key (to_key)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_tok_ff <= tok;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_tok_ff.kind;
   assign rsp_tlast  = out_tok_ff.done;
   assign rsp_tdata  = {2'b00, out_tok_ff.eoff, out_tok_ff.perr, out_tok_ff.tlast,
                        out_tok_ff.depth, out_tok_ff.index, out_tok_ff.in_array,
                        out_tok_ff.data};

   // ignored bytes carry no position or structure
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_tok_ff.kind == mpp_pkg::KIND_IGNORED) |->
         (!out_tok_ff.in_array && out_tok_ff.depth == '0 && !out_tok_ff.tlast))
      else $error("ignored item carries position fields");

   a_offset_only_on_error: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_tok_ff.perr) |-> (out_tok_ff.eoff == '0))
      else $error("error offset without error");

   a_index_only_in_array: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_tok_ff.in_array) |-> (out_tok_ff.index == '0))
      else $error("element index outside an array");

   a_result_follows_input: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("result lost after input item consumed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for msgpack_map_subset_parser. Bytes go in on the req_
// stream and are scored against an in-bench parser model that tracks map
// depth, array position, sticky error and byte offset. The bench starts with
// a short directed table of packets. It then sends random packets, mostly
// well formed with random content and some truncated, corrupted, padded or
// pure noise.
// ----------------------------------------------------------------------------

module tb;
   import mpp_pkg::*;

   localparam logic [7:0] FIXINT_LIMIT = 8'h80;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         RANDOM_BYTES = 2000;

   typedef enum logic [3:0] {
      P_TOP_HDR, P_MAP_LEN_HI, P_MAP_LEN_LO, P_KEY_HDR, P_KEY_LEN, P_KEY_BODY,
      P_VALUE, P_STR_BODY, P_FLOAT_BODY, P_ARR_LEN_HI, P_ARR_LEN_LO, P_ARR_ELEM,
      P_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       typed_in;
      tok_type    tok;
   } step_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_in
   logic        req_tlast  = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] data_byte, [8] in_array,
                                      // [24:9] element_index, [27:25] nest_depth,
                                      // [28] token_last, [29] parse_error,
                                      // [45:30] error_offset, [47:46] zero
   logic [2:0]  rsp_tuser;            // [2:0] token_kind
   logic        rsp_tlast;            // packet_done

   msgpack_map_subset_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser model state
   phase_type                phase;
   logic [15:0]              pairs_left [MAX_DEPTH];
   int unsigned              sp;
   logic [15:0]              arr_left;
   logic [15:0]              arr_idx;
   logic [7:0]               body_left;
   logic [7:0]               len_hi;
   bit                       err;
   logic [OFFSET_BITS-1:0]   offset;
   logic [OFFSET_BITS-1:0]   err_offset;

   tok_type     pending_tokens [$];
   tok_type     token_want;
   logic [7:0]  pkt_q [$];
   int          failures    = 0;
   int          sent_bytes  = 0;
   bit          calm        = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left   = 0;

   // directed packets: plain, trailing bytes, bad top header, empty top map,
   // truncated inside a map, array within an array, empty array
   step_row_type directed_rows [0:24] = '{
      '{8'h81, 1'b0, 1'b1, '{KIND_STRUCT,  8'h81, 1'b0, 16'd0, 3'd0, 1'b0, 1'b0, 16'd0, 1'b0}},
      '{8'hA1, 1'b0, 1'b0, '0},
      '{8'h7A, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b1, '{KIND_UINT,    8'h7F, 1'b0, 16'd0, 3'd0, 1'b0, 1'b0, 16'd0, 1'b1}},
      '{8'hFF, 1'b1, 1'b1, '{KIND_IGNORED, 8'hFF, 1'b0, 16'd0, 3'd0, 1'b0, 1'b0, 16'd0, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{KIND_IGNORED, 8'h00, 1'b0, 16'd0, 3'd0, 1'b0, 1'b1, 16'd0, 1'b0}},
      '{8'h80, 1'b1, 1'b1, '{KIND_IGNORED, 8'h80, 1'b0, 16'd0, 3'd0, 1'b0, 1'b1, 16'd0, 1'b1}},
      '{8'h80, 1'b1, 1'b1, '{KIND_STRUCT,  8'h80, 1'b0, 16'd0, 3'd0, 1'b0, 1'b0, 16'd0, 1'b1}},
      '{8'hDE, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'hD9, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hCA, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h3F, 1'b1, 1'b1, '{KIND_FLOAT,   8'h3F, 1'b0, 16'd0, 3'd0, 1'b1, 1'b1, 16'd9, 1'b1}},
      '{8'h81, 1'b0, 1'b0, '0},
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h91, 1'b0, 1'b0, '0},
      '{8'h91, 1'b1, 1'b1, '{KIND_IGNORED, 8'h91, 1'b0, 16'd0, 3'd0, 1'b0, 1'b1, 16'd3, 1'b1}},
      '{8'h81, 1'b0, 1'b0, '0},
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h90, 1'b1, 1'b1, '{KIND_STRUCT,  8'h90, 1'b0, 16'd0, 3'd0, 1'b0, 1'b0, 16'd0, 1'b1}}
   };

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------
   function automatic void reset_parser();
      phase = P_TOP_HDR;
      foreach (pairs_left[i]) pairs_left[i] = '0;
      sp         = 0;
      arr_left   = '0;
      arr_idx    = '0;
      body_left  = '0;
      len_hi     = '0;
      err        = 1'b0;
      offset     = '0;
      err_offset = '0;
   endfunction

   // one value of the open map is finished; pop every map that ran out
   function automatic void close_value();
      bit searching;
      searching = 1'b1;
      while (searching) begin
         if (pairs_left[sp] != 0) pairs_left[sp]--;
         if (pairs_left[sp] != 0) begin
            phase = P_KEY_HDR;
            searching = 1'b0;
         end else if (sp == 0) begin
            phase = P_DONE;
            searching = 1'b0;
         end else begin
            sp--;
         end
      end
   endfunction

   function automatic void open_map(logic [15:0] n);
      pairs_left[sp] = n;
      if (n != 0) begin
         phase = P_KEY_HDR;
      end else if (sp == 0) begin
         phase = P_DONE;
      end else begin
         sp--;
         close_value();
      end
   endfunction

   function automatic void open_array(logic [15:0] n);
      arr_idx  = '0;
      arr_left = n;
      if (n != 0) phase = P_ARR_ELEM;
      else close_value();
   endfunction

   function automatic void close_element();
      arr_left--;
      arr_idx++;
      if (arr_left == 0) begin
         arr_idx = '0;
         close_value();
      end else begin
         phase = P_ARR_ELEM;
      end
   endfunction

   function automatic void close_content();
      if (arr_left != 0) close_element();
      else close_value();
   endfunction

   function automatic tok_type parse_byte(logic [7:0] b, bit last);
      tok_type t;
      bit      was_done;
      bit      bad;
      t        = '0;
      t.kind   = KIND_STRUCT;
      t.data   = b;
      t.depth  = sp[2:0];
      was_done = (phase == P_DONE);
      bad      = 1'b0;
      if (err || was_done) begin
         t.kind  = KIND_IGNORED;
         t.depth = '0;
      end else begin
         case (phase)
            P_TOP_HDR: begin
               if (b[7:4] == PFX_FIXMAP) begin
                  sp = 0;
                  open_map({12'd0, b[3:0]});
               end else if (b == HDR_MAP16) begin
                  sp = 0;
                  phase = P_MAP_LEN_HI;
               end else begin
                  bad = 1'b1;
               end
            end
            P_MAP_LEN_HI: begin
               len_hi = b;
               phase  = P_MAP_LEN_LO;
            end
            P_MAP_LEN_LO: open_map({len_hi, b});
            P_KEY_HDR: begin
               if (b[7:5] == PFX_FIXSTR) begin
                  body_left = {3'd0, b[4:0]};
                  phase = (body_left != 0) ? P_KEY_BODY : P_VALUE;
               end else if (b == HDR_STR8) begin
                  phase = P_KEY_LEN;
               end else begin
                  bad = 1'b1;
               end
            end
            P_KEY_LEN: begin
               body_left = b;
               phase = (body_left != 0) ? P_KEY_BODY : P_VALUE;
            end
            P_KEY_BODY: begin
               t.kind = KIND_KEY;
               if (body_left <= 1) begin
                  t.tlast   = 1'b1;
                  body_left = '0;
                  phase     = P_VALUE;
               end else begin
                  body_left--;
               end
            end
            P_VALUE: begin
               if (b < FIXINT_LIMIT) begin
                  t.kind = KIND_UINT;
                  close_value();
               end else if (b[7:5] == PFX_FIXSTR) begin
                  body_left = {3'd0, b[4:0]};
                  if (body_left != 0) phase = P_STR_BODY;
                  else close_value();
               end else if (b == HDR_FLOAT32) begin
                  body_left = FLOAT_BYTES;
                  phase     = P_FLOAT_BODY;
               end else if (b[7:4] == PFX_FIXARR) begin
                  open_array({12'd0, b[3:0]});
               end else if (b == HDR_ARRAY16) begin
                  phase = P_ARR_LEN_HI;
               end else if (b[7:4] == PFX_FIXMAP || b == HDR_MAP16) begin
                  if (sp + 1 >= MAX_DEPTH) begin
                     bad = 1'b1;
                  end else begin
                     sp++;
                     if (b == HDR_MAP16) phase = P_MAP_LEN_HI;
                     else open_map({12'd0, b[3:0]});
                  end
               end else begin
                  bad = 1'b1;
               end
            end
            P_STR_BODY, P_FLOAT_BODY: begin
               t.kind = (phase == P_STR_BODY) ? KIND_STRING : KIND_FLOAT;
               if (arr_left != 0) begin
                  t.in_array = 1'b1;
                  t.index    = arr_idx;
               end
               if (body_left <= 1) begin
                  t.tlast   = 1'b1;
                  body_left = '0;
                  close_content();
               end else begin
                  body_left--;
               end
            end
            P_ARR_LEN_HI: begin
               len_hi = b;
               phase  = P_ARR_LEN_LO;
            end
            P_ARR_LEN_LO: open_array({len_hi, b});
            P_ARR_ELEM: begin
               t.in_array = 1'b1;
               t.index    = arr_idx;
               if (b < FIXINT_LIMIT) begin
                  t.kind = KIND_UINT;
                  close_element();
               end else if (b[7:5] == PFX_FIXSTR) begin
                  body_left = {3'd0, b[4:0]};
                  if (body_left != 0) phase = P_STR_BODY;
                  else close_element();
               end else if (b == HDR_FLOAT32) begin
                  body_left = FLOAT_BYTES;
                  phase     = P_FLOAT_BODY;
               end else begin
                  bad = 1'b1;
               end
            end
            default: bad = 1'b1;
         endcase
         if (bad) begin
            err        = 1'b1;
            err_offset = offset;
            t.kind     = KIND_IGNORED;
            t.in_array = 1'b0;
            t.index    = '0;
            t.depth    = '0;
            t.tlast    = 1'b0;
         end
      end
      // packet ended before the top map closed
      if (last && !err && phase != P_DONE) begin
         err        = 1'b1;
         err_offset = offset;
      end
      t.perr = err;
      t.eoff = err ? err_offset[15:0] : 16'd0;
      t.done = last || (!was_done && phase == P_DONE);
      if (offset != OFFSET_MAX) offset++;
      if (last) reset_parser();
      return t;
   endfunction

   // ------------------------------------------------------------------------
   // random packet builder
   // ------------------------------------------------------------------------
   function automatic void put_random(int n);
      repeat (n) pkt_q.push_back(8'($urandom));
   endfunction

   function automatic void gen_key();
      int n;
      if ($urandom_range(9) < 7) begin
         n = ($urandom_range(9) == 0) ? 31 : $urandom_range(4);
         pkt_q.push_back({PFX_FIXSTR, 5'(n)});
      end else begin
         n = ($urandom_range(14) == 0) ? 255 : $urandom_range(40);
         pkt_q.push_back(HDR_STR8);
         pkt_q.push_back(8'(n));
      end
      put_random(n);
   endfunction

   function automatic void gen_scalar();
      int n;
      case ($urandom_range(2))
         0: pkt_q.push_back(8'($urandom_range(127)));
         1: begin
            n = ($urandom_range(19) == 0) ? 31 : $urandom_range(5);
            pkt_q.push_back({PFX_FIXSTR, 5'(n)});
            put_random(n);
         end
         default: begin
            pkt_q.push_back(HDR_FLOAT32);
            put_random(4);
         end
      endcase
   endfunction

   function automatic void gen_value(int level, int chain);
      int n;
      if (chain > 0 || ($urandom_range(7) == 0 && level < 9)) begin
         gen_map(level + 1, (chain > 0) ? chain - 1 : 0);
      end else begin
         case ($urandom_range(5))
            3: begin
               n = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4);
               pkt_q.push_back({PFX_FIXARR, 4'(n)});
               repeat (n) gen_scalar();
            end
            4: begin
               n = ($urandom_range(40) == 0) ? 256 + $urandom_range(3) : $urandom_range(5);
               pkt_q.push_back(HDR_ARRAY16);
               pkt_q.push_back(8'(n >> 8));
               pkt_q.push_back(8'(n));
               repeat (n) gen_scalar();
            end
            default: gen_scalar();
         endcase
      end
   endfunction

   function automatic void gen_map(int level, int chain);
      int n;
      if (chain > 0) n = 1;
      else if ($urandom_range(9) == 0 && level < 2) n = $urandom_range(15);
      else n = $urandom_range(3);
      if ($urandom_range(3) == 0) begin
         pkt_q.push_back(HDR_MAP16);
         pkt_q.push_back(8'(n >> 8));
         pkt_q.push_back(8'(n));
      end else begin
         pkt_q.push_back({PFX_FIXMAP, 4'(n)});
      end
      for (int i = 0; i < n; i++) begin
         gen_key();
         gen_value(level, chain);
      end
   endfunction

   // mostly intact packets; the rest truncated, hit by a stray byte,
   // padded after the top map, or plain noise
   function automatic void build_packet();
      int r;
      pkt_q.delete();
      gen_map(0, ($urandom_range(5) == 0) ? $urandom_range(5, 9) : 0);
      r = $urandom_range(99);
      if (r < 55) begin
      end else if (r < 65 && pkt_q.size() > 1) begin
         r = $urandom_range(1, pkt_q.size() - 1);
         while (pkt_q.size() > r) void'(pkt_q.pop_back());
      end else if (r < 75) begin
         pkt_q[$urandom_range(pkt_q.size() - 1)] = 8'($urandom);
      end else if (r < 85) begin
         put_random($urandom_range(1, 4));
      end else begin
         pkt_q.delete();
         put_random($urandom_range(1, 8));
      end
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input bit last,
                            input bit typed_in, input tok_type typed);
      tok_type tok;
      while (!calm && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tok = parse_byte(value, last);
      if (typed_in) tok = typed;
      pending_tokens.push_back(tok);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, field_name, want, got);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 32);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t unexpected token: expected none, actual kind %h data %h done %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            token_want = pending_tokens.pop_front();
            check_field("token_kind",    16'(token_want.kind),     16'(rsp_tuser));
            check_field("data_byte",     16'(token_want.data),     16'(rsp_tdata[7:0]));
            check_field("in_array",      16'(token_want.in_array), 16'(rsp_tdata[8]));
            check_field("element_index", token_want.index,         rsp_tdata[24:9]);
            check_field("nest_depth",    16'(token_want.depth),    16'(rsp_tdata[27:25]));
            check_field("token_last",    16'(token_want.tlast),    16'(rsp_tdata[28]));
            check_field("parse_error",   16'(token_want.perr),     16'(rsp_tdata[29]));
            check_field("error_offset",  token_want.eoff,          rsp_tdata[45:30]);
            check_field("packet_done",   16'(token_want.done),     16'(rsp_tlast));
         end
      end
   end

   initial begin
      reset_parser();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].value, directed_rows[i].last,
                   directed_rows[i].typed_in, directed_rows[i].tok);
      wait_drained();

      // long receiver hold-off with the sender pushing back to back
      calm = 1'b1;
      hold_request = 1'b1;
      repeat (4) begin
         build_packet();
         send_packet();
      end
      calm = 1'b0;
      wait_drained();

      while (sent_bytes < RANDOM_BYTES) begin
         calm = (sent_bytes > 900 && sent_bytes < 1200);
         build_packet();
         send_packet();
      end
      calm = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
